// File: hw/rtl/particle_density_splat_grid_defines.svh
// assertion macros for the density splat grid
// used by the rtl files that carry concurrent checks; expects clk and rst_n in scope
`ifndef PARTICLE_DENSITY_SPLAT_GRID_DEFINES_SVH
`define PARTICLE_DENSITY_SPLAT_GRID_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PDSG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdsg same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define PDSG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdsg next-cycle check failed");

`endif

// File: hw/rtl/pdsg_pkg.sv
// shared types, constants and helpers for the density splat grid
// no dependencies; used by every rtl module of the block except pdsg_ram
`default_nettype none

package pdsg_pkg;

  // grid geometry
  localparam int GRID_X = 16;
  localparam int GRID_Y = 16;
  localparam int GRID_Z = 16;
  localparam int GRID_MAX = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z)
                                              : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
  localparam int COORD_W = $clog2(GRID_MAX);

  // density store
  localparam int STORE_DEPTH = 4096;
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int DATA_W = 32;
  localparam int CELL_W = (3 * COORD_W + 1 > IDX_W) ? (3 * COORD_W + 1) : IDX_W;

  // shared multiplier geometry
  localparam int MUL_A_W = 40;
  localparam int MUL_B_W = 24;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W = 57;

  // field widths
  localparam int POS_W = 32;
  localparam int RAD_W = 24;

  // operation codes
  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_READ     = 2'd1;
  localparam logic [1:0] OP_READ_CLR = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY_SCALE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_RADIUS = 3'd7;

  // register reset values
  localparam logic [31:0] RST_ORIGIN        = 32'd0;
  localparam logic [31:0] RST_SCALE         = 32'd65536;
  localparam logic [31:0] RST_DENSITY_SCALE = 32'd274503;
  localparam logic [RAD_W-1:0] RST_GLOBAL_RADIUS = 24'd65536;

  // axis counter codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [31:0]      origin_x;
    logic [31:0]      origin_y;
    logic [31:0]      origin_z;
    logic [31:0]      scale_x;
    logic [31:0]      scale_y;
    logic [31:0]      scale_z;
    logic [31:0]      density_scale;
    logic [RAD_W-1:0] global_radius;
  } cfg_regs_t;

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AX_HI,
    ST_AX_LO,
    ST_AX_FIN,
    ST_CELL,
    ST_R3,
    ST_DH,
    ST_DL,
    ST_INC,
    ST_SUM,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  // largest legal coordinate on an axis
  function automatic logic [COORD_W-1:0] axis_limit(input logic [1:0] axis);
    logic [COORD_W-1:0] lim;
    unique case (axis)
      AXIS_X:  lim = COORD_W'(GRID_X - 1);
      AXIS_Y:  lim = COORD_W'(GRID_Y - 1);
      AXIS_Z:  lim = COORD_W'(GRID_Z - 1);
      default: lim = '0;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/particle_density_splat_grid.sv
// nearest-grid-point density binning into a 16x16x16 Q16.16 voxel store
// an add bins each axis in turn, forms the volume term, then reads, adds and writes back the voxel
// requests: one at a time, busy until the result is issued; adds use the shared 40x24 multiplier
// reset: registers to defaults, then a clearing pass over the whole store with busy high
// the result strobe lasts one cycle and cannot be held off; cfg writes are always taken
// depends on pdsg_pkg, pdsg_ctrl, pdsg_mul, pdsg_ram
`default_nettype none

module particle_density_splat_grid (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // request channel
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic [1:0]                             in_operation,
  input  wire logic signed [pdsg_pkg::POS_W-1:0]      in_pos_x,
  input  wire logic signed [pdsg_pkg::POS_W-1:0]      in_pos_y,
  input  wire logic signed [pdsg_pkg::POS_W-1:0]      in_pos_z,
  input  wire logic                                   in_own_radius,
  input  wire logic [pdsg_pkg::RAD_W-1:0]             in_radius,
  input  wire logic [pdsg_pkg::IDX_W-1:0]             in_read_index,
  // configuration write channel
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [pdsg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [31:0]                            cfg_data,
  // result channel
  output logic                                        out_valid,
  output logic [pdsg_pkg::IDX_W-1:0]                  out_cell_index,
  output logic [pdsg_pkg::DATA_W-1:0]                 out_density,
  output logic                                        out_saturated
);

  pdsg_pkg::cfg_regs_t                 cfg_r, cfg_nxt;
  pdsg_pkg::mul_req_t                  mul_req;
  logic [pdsg_pkg::PROD_W-1:0]         prod;
  logic                                ram_we;
  logic [pdsg_pkg::IDX_W-1:0]          ram_waddr;
  logic [pdsg_pkg::DATA_W-1:0]         ram_wdata;
  logic [pdsg_pkg::IDX_W-1:0]          ram_raddr;
  logic [pdsg_pkg::DATA_W-1:0]         ram_rdata;

  // user must change registers only while idle; block does not enforce it; writes always taken
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pdsg_pkg::REG_ORIGIN_X:      cfg_nxt.origin_x      = cfg_data;
        pdsg_pkg::REG_ORIGIN_Y:      cfg_nxt.origin_y      = cfg_data;
        pdsg_pkg::REG_ORIGIN_Z:      cfg_nxt.origin_z      = cfg_data;
        pdsg_pkg::REG_SCALE_X:       cfg_nxt.scale_x       = cfg_data;
        pdsg_pkg::REG_SCALE_Y:       cfg_nxt.scale_y       = cfg_data;
        pdsg_pkg::REG_SCALE_Z:       cfg_nxt.scale_z       = cfg_data;
        pdsg_pkg::REG_DENSITY_SCALE: cfg_nxt.density_scale = cfg_data;
        // radius is Q8.16, upper byte of the write is dropped
        pdsg_pkg::REG_GLOBAL_RADIUS: cfg_nxt.global_radius = cfg_data[pdsg_pkg::RAD_W-1:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= pdsg_pkg::RST_ORIGIN;
      cfg_r.origin_y      <= pdsg_pkg::RST_ORIGIN;
      cfg_r.origin_z      <= pdsg_pkg::RST_ORIGIN;
      cfg_r.scale_x       <= pdsg_pkg::RST_SCALE;
      cfg_r.scale_y       <= pdsg_pkg::RST_SCALE;
      cfg_r.scale_z       <= pdsg_pkg::RST_SCALE;
      cfg_r.density_scale <= pdsg_pkg::RST_DENSITY_SCALE;
      cfg_r.global_radius <= pdsg_pkg::RST_GLOBAL_RADIUS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer: clearing pass, binning, volume term, read-modify-write of the voxel and reads
  pdsg_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_own_radius  (in_own_radius),
    .in_radius      (in_radius),
    .in_read_index  (in_read_index),
    .cfg            (cfg_r),
    .mul_req        (mul_req),
    .prod           (prod),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_cell_index (out_cell_index),
    .out_density    (out_density),
    .out_saturated  (out_saturated)
  );

  // one multiplier shared by every product of an add request
  pdsg_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod)
  );

  // voxel density store
  pdsg_ram #(
    .WIDTH (pdsg_pkg::DATA_W),
    .DEPTH (pdsg_pkg::STORE_DEPTH)
  ) u_grid_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

endmodule

`default_nettype wire

// File: hw/rtl/pdsg_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module pdsg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/pdsg_mul.sv
// shared unsigned multiplier with a registered product
// depends on pdsg_pkg
`default_nettype none

module pdsg_mul (
  input  wire logic                        clk,
  input  wire pdsg_pkg::mul_req_t          req,
  output logic [pdsg_pkg::PROD_W-1:0]      prod_r
);

  logic [pdsg_pkg::PROD_W-1:0] prod_nxt;

  assign prod_nxt = pdsg_pkg::PROD_W'(req.a) * pdsg_pkg::PROD_W'(req.b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/pdsg_ctrl.sv
// sequencer and datapath registers: axis binning, volume term, read-modify-write
// depends on pdsg_pkg and particle_density_splat_grid_defines.svh
`default_nettype none
`include "particle_density_splat_grid_defines.svh"

module pdsg_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          in_operation,
  input  wire logic signed [pdsg_pkg::POS_W-1:0]   in_pos_x,
  input  wire logic signed [pdsg_pkg::POS_W-1:0]   in_pos_y,
  input  wire logic signed [pdsg_pkg::POS_W-1:0]   in_pos_z,
  input  wire logic                                in_own_radius,
  input  wire logic [pdsg_pkg::RAD_W-1:0]          in_radius,
  input  wire logic [pdsg_pkg::IDX_W-1:0]          in_read_index,
  input  wire pdsg_pkg::cfg_regs_t                 cfg,
  output pdsg_pkg::mul_req_t                       mul_req,
  input  wire logic [pdsg_pkg::PROD_W-1:0]         prod,
  output logic                                     ram_we,
  output logic [pdsg_pkg::IDX_W-1:0]               ram_waddr,
  output logic [pdsg_pkg::DATA_W-1:0]              ram_wdata,
  output logic [pdsg_pkg::IDX_W-1:0]               ram_raddr,
  input  wire logic [pdsg_pkg::DATA_W-1:0]         ram_rdata,
  output logic                                     out_valid,
  output logic [pdsg_pkg::IDX_W-1:0]               out_cell_index,
  output logic [pdsg_pkg::DATA_W-1:0]              out_density,
  output logic                                     out_saturated
);

  pdsg_pkg::state_t state_r, state_nxt;
  logic [1:0]                       axis_r, axis_nxt;
  logic [pdsg_pkg::IDX_W-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [1:0]                       op_r, op_nxt;
  logic [32:0]                      d_r [3];
  logic [32:0]                      d_nxt [3];
  logic [pdsg_pkg::COORD_W-1:0]     coord_r [3];
  logic [pdsg_pkg::COORD_W-1:0]     coord_nxt [3];
  logic [pdsg_pkg::RAD_W-1:0]       rad_r, rad_nxt;
  logic [pdsg_pkg::IDX_W-1:0]       cell_r, cell_nxt;
  logic [pdsg_pkg::ACC_W-1:0]       acc_r, acc_nxt;
  logic [39:0]                      r3_r, r3_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [pdsg_pkg::IDX_W-1:0]       out_cell_r, out_cell_nxt;
  logic [pdsg_pkg::DATA_W-1:0]      out_density_r, out_density_nxt;
  logic                             out_sat_r, out_sat_nxt;

  logic                             accept;
  logic [32:0]                      d_sel;
  logic [31:0]                      scale_sel;
  logic                             d_pos;
  logic [48:0]                      fin_sum;
  logic [32:0]                      fin_idx;
  logic [pdsg_pkg::COORD_W-1:0]     lim;
  logic [pdsg_pkg::CELL_W-1:0]      cell_full;
  logic [pdsg_pkg::ACC_W:0]         sum;
  logic                             sum_sat;

  assign busy   = (state_r != pdsg_pkg::ST_IDLE);
  assign accept = start && !busy;

  // operands of the axis currently being binned
  always_comb begin
    d_sel = d_r[axis_r];
    unique case (axis_r)
      pdsg_pkg::AXIS_X: scale_sel = cfg.scale_x;
      pdsg_pkg::AXIS_Y: scale_sel = cfg.scale_y;
      pdsg_pkg::AXIS_Z: scale_sel = cfg.scale_z;
      default:          scale_sel = '0;
    endcase
  end

  assign d_pos   = !d_sel[32] && (d_sel != '0);
  assign fin_sum = acc_r[48:0] + {17'd0, prod[47:16]};
  assign fin_idx = fin_sum[48:16];
  assign lim     = pdsg_pkg::axis_limit(axis_r);

  assign cell_full = pdsg_pkg::CELL_W'(coord_r[0])
                   + (pdsg_pkg::CELL_W'(coord_r[1])
                      + pdsg_pkg::CELL_W'(coord_r[2]) * pdsg_pkg::CELL_W'(pdsg_pkg::GRID_Y))
                     * pdsg_pkg::CELL_W'(pdsg_pkg::GRID_X);

  assign sum     = {{(pdsg_pkg::ACC_W + 1 - pdsg_pkg::DATA_W){1'b0}}, ram_rdata}
                 + {1'b0, acc_r};
  assign sum_sat = (sum[pdsg_pkg::ACC_W:pdsg_pkg::DATA_W] != '0);

  assign ram_raddr = cell_r;

  always_comb begin
    state_nxt       = state_r;
    axis_nxt        = axis_r;
    clr_cnt_nxt     = clr_cnt_r;
    op_nxt          = op_r;
    d_nxt           = d_r;
    coord_nxt       = coord_r;
    rad_nxt         = rad_r;
    cell_nxt        = cell_r;
    acc_nxt         = acc_r;
    r3_nxt          = r3_r;
    out_valid_nxt   = 1'b0;
    out_cell_nxt    = out_cell_r;
    out_density_nxt = out_density_r;
    out_sat_nxt     = out_sat_r;
    mul_req.a       = '0;
    mul_req.b       = '0;
    ram_we          = 1'b0;
    ram_waddr       = cell_r;
    ram_wdata       = '0;

    unique case (state_r)
      pdsg_pkg::ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = pdsg_pkg::ST_IDLE;
        end
      end
      pdsg_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_operation;
          d_nxt[0] = {in_pos_x[31], in_pos_x} - {cfg.origin_x[31], cfg.origin_x};
          d_nxt[1] = {in_pos_y[31], in_pos_y} - {cfg.origin_y[31], cfg.origin_y};
          d_nxt[2] = {in_pos_z[31], in_pos_z} - {cfg.origin_z[31], cfg.origin_z};
          rad_nxt  = in_own_radius ? in_radius : cfg.global_radius;
          cell_nxt = in_read_index;
          axis_nxt = pdsg_pkg::AXIS_X;
          if (in_operation == pdsg_pkg::OP_ADD) begin
            state_nxt = pdsg_pkg::ST_AX_HI;
          end else begin
            state_nxt = pdsg_pkg::ST_RD_ADDR;
          end
        end
      end
      // upper half of the offset times scale
      pdsg_pkg::ST_AX_HI: begin
        mul_req.a = {8'd0, scale_sel};
        mul_req.b = {8'd0, d_sel[31:16]};
        state_nxt = pdsg_pkg::ST_AX_LO;
      end
      // lower half of the offset times scale
      pdsg_pkg::ST_AX_LO: begin
        acc_nxt   = {9'd0, prod[47:0]};
        mul_req.a = {8'd0, scale_sel};
        mul_req.b = {8'd0, d_sel[15:0]};
        state_nxt = pdsg_pkg::ST_AX_FIN;
      end
      pdsg_pkg::ST_AX_FIN: begin
        if (!d_pos) begin
          coord_nxt[axis_r] = '0;
        end else if (fin_idx > 33'(lim)) begin
          coord_nxt[axis_r] = lim;
        end else begin
          coord_nxt[axis_r] = fin_idx[pdsg_pkg::COORD_W-1:0];
        end
        if (axis_r == pdsg_pkg::AXIS_Z) begin
          state_nxt = pdsg_pkg::ST_CELL;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = pdsg_pkg::ST_AX_HI;
        end
      end
      // linear index, r*r
      pdsg_pkg::ST_CELL: begin
        cell_nxt  = cell_full[pdsg_pkg::IDX_W-1:0];
        mul_req.a = {16'd0, rad_r};
        mul_req.b = rad_r;
        state_nxt = pdsg_pkg::ST_R3;
      end
      // r2*r
      pdsg_pkg::ST_R3: begin
        mul_req.a = {8'd0, prod[47:16]};
        mul_req.b = rad_r;
        state_nxt = pdsg_pkg::ST_DH;
      end
      // r3 times integer part of density scale
      pdsg_pkg::ST_DH: begin
        r3_nxt    = prod[55:16];
        mul_req.a = prod[55:16];
        mul_req.b = {8'd0, cfg.density_scale[31:16]};
        state_nxt = pdsg_pkg::ST_DL;
      end
      // r3 times fraction of density scale
      pdsg_pkg::ST_DL: begin
        acc_nxt   = {1'b0, prod[55:0]};
        mul_req.a = r3_r;
        mul_req.b = {8'd0, cfg.density_scale[15:0]};
        state_nxt = pdsg_pkg::ST_INC;
      end
      // finish the increment while the old voxel value is read
      pdsg_pkg::ST_INC: begin
        acc_nxt   = acc_r + {17'd0, prod[55:16]};
        state_nxt = pdsg_pkg::ST_SUM;
      end
      pdsg_pkg::ST_SUM: begin
        ram_we          = 1'b1;
        ram_wdata       = sum_sat ? '1 : sum[pdsg_pkg::DATA_W-1:0];
        out_valid_nxt   = 1'b1;
        out_cell_nxt    = cell_r;
        out_density_nxt = ram_wdata;
        out_sat_nxt     = sum_sat;
        state_nxt       = pdsg_pkg::ST_IDLE;
      end
      pdsg_pkg::ST_RD_ADDR: begin
        state_nxt = pdsg_pkg::ST_RD_DATA;
      end
      pdsg_pkg::ST_RD_DATA: begin
        ram_we          = (op_r == pdsg_pkg::OP_READ_CLR);
        out_valid_nxt   = 1'b1;
        out_cell_nxt    = cell_r;
        out_density_nxt = ram_rdata;
        out_sat_nxt     = 1'b0;
        state_nxt       = pdsg_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pdsg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pdsg_pkg::ST_CLEAR;
      axis_r      <= pdsg_pkg::AXIS_X;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    d_r           <= d_nxt;
    coord_r       <= coord_nxt;
    rad_r         <= rad_nxt;
    cell_r        <= cell_nxt;
    acc_r         <= acc_nxt;
    r3_r          <= r3_nxt;
    out_cell_r    <= out_cell_nxt;
    out_density_r <= out_density_nxt;
    out_sat_r     <= out_sat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_index = out_cell_r;
  assign out_density    = out_density_r;
  assign out_saturated  = out_sat_r;

  `PDSG_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r)
  `PDSG_ASSERT_NEXT(a_sum_gives_result, state_r == pdsg_pkg::ST_SUM, out_valid_r)
  `PDSG_ASSERT_IMPL(a_sat_is_full, out_valid_r && out_sat_r, out_density_r == '1)
  `PDSG_ASSERT_IMPL(a_no_write_idle, state_r == pdsg_pkg::ST_IDLE, !ram_we)

endmodule

`default_nettype wire

// File: bench/particle_density_splat_grid_test.sv
// self-checking bench for the density splat grid: drives particle and read requests,
// bins them in a local voxel model and compares every result strobe field by field
// depends on pdsg_pkg and the particle_density_splat_grid rtl top
module particle_density_splat_grid_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pdsg_pkg::*;

  // code three is not named in the package; the block treats it as a plain read
  localparam logic [1:0] OP_READ_ALT = 2'd3;
  // far beyond the slowest legal run (clear pass plus ~950 requests, each with its
  // longest idle burst)
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 32;

  typedef struct {
    logic [1:0]       op;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic             own_radius;
    logic [RAD_W-1:0] radius;
    logic [IDX_W-1:0] read_index;
  } particle_req_t;

  typedef struct {
    logic [IDX_W-1:0]  cell_idx;
    logic [DATA_W-1:0] density;
    logic              saturated;
  } voxel_result_t;

  // dut connections
  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_operation;
  logic [POS_W-1:0]     in_pos_x;
  logic [POS_W-1:0]     in_pos_y;
  logic [POS_W-1:0]     in_pos_z;
  logic                 in_own_radius;
  logic [RAD_W-1:0]     in_radius;
  logic [IDX_W-1:0]     in_read_index;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 out_valid;
  logic [IDX_W-1:0]     out_cell_index;
  logic [DATA_W-1:0]    out_density;
  logic                 out_saturated;

  // voxel model: config copy, density store and results still owed by the block
  cfg_regs_t         grid_cfg;
  logic [DATA_W-1:0] voxel_store [STORE_DEPTH];
  voxel_result_t     pending_voxels[$];
  voxel_result_t     oldest_voxel;
  logic [IDX_W-1:0]  hot_cells[$];
  int                error_count = 0;
  int                cycle_count = 0;
  int                idle_pct = 0;

  particle_density_splat_grid u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_own_radius  (in_own_radius),
    .in_radius      (in_radius),
    .in_read_index  (in_read_index),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_cell_index (out_cell_index),
    .out_density    (out_density),
    .out_saturated  (out_saturated)
  );

  // 4 ns clock, first rising edge at 2 ns
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // voxel model
  // ---------------------------------------------------------------------------

  // nearest grid point on one axis: truncated (pos - origin) * scale, clamped to the grid
  function automatic int unsigned axis_bin(logic [POS_W-1:0] pos, logic [31:0] origin,
                                           logic [31:0] scale, int unsigned size);
    longint p;
    longint o;
    longint d;
    longint unsigned ud;
    longint unsigned bin;
    p = $signed(pos);
    o = $signed(origin);
    d = p - o;
    // at or below the origin lands in the first voxel
    if (d <= 0) return 0;
    ud = d;
    // split multiply keeps the low half's truncation where the hardware has it
    bin = (((ud >> 16) * scale) + (((ud & 64'hFFFF) * scale) >> 16)) >> 16;
    if (bin >= size) bin = size - 1;
    return bin;
  endfunction

  // density_scale * r^3 with truncation after every product
  function automatic longint unsigned splat_volume(logic [RAD_W-1:0] r, logic [31:0] ds);
    longint unsigned rr;
    longint unsigned r2;
    longint unsigned r3;
    rr = r;
    r2 = (rr * rr) >> 16;
    r3 = (r2 * rr) >> 16;
    return r3 * (ds >> 16) + ((r3 * ds[15:0]) >> 16);
  endfunction

  // apply one request to the store and return the result it must produce
  function automatic voxel_result_t bin_particle(particle_req_t r);
    voxel_result_t   res;
    int unsigned     x;
    int unsigned     y;
    int unsigned     z;
    logic [RAD_W-1:0] rad;
    longint unsigned sum;
    res.saturated = 1'b0;
    if (r.op == OP_ADD) begin
      x = axis_bin(r.pos_x, grid_cfg.origin_x, grid_cfg.scale_x, GRID_X);
      y = axis_bin(r.pos_y, grid_cfg.origin_y, grid_cfg.scale_y, GRID_Y);
      z = axis_bin(r.pos_z, grid_cfg.origin_z, grid_cfg.scale_z, GRID_Z);
      // linear index wraps at the store depth
      res.cell_idx = IDX_W'(x + (y + z * GRID_Y) * GRID_X);
      rad = r.own_radius ? r.radius : grid_cfg.global_radius;
      sum = voxel_store[res.cell_idx];
      sum = sum + splat_volume(rad, grid_cfg.density_scale);
      if (sum > 64'hFFFF_FFFF) begin
        sum = 64'hFFFF_FFFF;
        res.saturated = 1'b1;
      end
      res.density = DATA_W'(sum);
      voxel_store[res.cell_idx] = res.density;
    end else begin
      // read, read-and-clear and code three all return the stored word
      res.cell_idx = r.read_index;
      res.density = voxel_store[res.cell_idx];
      if (r.op == OP_READ_CLR) voxel_store[res.cell_idx] = '0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: the block cannot be stalled, so every strobe is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_voxels.size() == 0) begin
        $display("%0t: result with nothing pending, actual cell %0d density %h sat %b",
                 $time, out_cell_index, out_density, out_saturated);
        error_count++;
      end else begin
        oldest_voxel = pending_voxels.pop_front();
        if (out_cell_index !== oldest_voxel.cell_idx) begin
          $display("%0t: cell_index expected %0d actual %0d",
                   $time, oldest_voxel.cell_idx, out_cell_index);
          error_count++;
        end
        if (out_density !== oldest_voxel.density) begin
          $display("%0t: density expected %h actual %h",
                   $time, oldest_voxel.density, out_density);
          error_count++;
        end
        if (out_saturated !== oldest_voxel.saturated) begin
          $display("%0t: saturated expected %b actual %b",
                   $time, oldest_voxel.saturated, out_saturated);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request and config drivers
  // ---------------------------------------------------------------------------

  // one request: optional idle burst, then hold start until the block takes it;
  // start stays high afterwards so back-to-back requests need no second assignment
  task automatic send_request(input particle_req_t r);
    voxel_result_t res;
    if ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start         <= 1'b1;
    in_operation  <= r.op;
    in_pos_x      <= r.pos_x;
    in_pos_y      <= r.pos_y;
    in_pos_z      <= r.pos_z;
    in_own_radius <= r.own_radius;
    in_radius     <= r.radius;
    in_read_index <= r.read_index;
    do @(posedge clk); while (busy !== 1'b0);
    // taken at this edge: predict in acceptance order
    res = bin_particle(r);
    pending_voxels.push_back(res);
    if (r.op == OP_ADD) begin
      hot_cells.push_back(res.cell_idx);
      if (hot_cells.size() > 48) void'(hot_cells.pop_front());
    end
  endtask

  // drop start and wait until every result is in and the block is idle
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_voxels.size() != 0 || busy !== 1'b0);
  endtask

  // leaves cfg_valid high; load_grid_config drops it after the last register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic load_grid_config(input cfg_regs_t c);
    wait_idle();
    write_reg(REG_ORIGIN_X, c.origin_x);
    write_reg(REG_ORIGIN_Y, c.origin_y);
    write_reg(REG_ORIGIN_Z, c.origin_z);
    write_reg(REG_SCALE_X, c.scale_x);
    write_reg(REG_SCALE_Y, c.scale_y);
    write_reg(REG_SCALE_Z, c.scale_z);
    write_reg(REG_DENSITY_SCALE, c.density_scale);
    write_reg(REG_GLOBAL_RADIUS, 32'(c.global_radius));
    cfg_valid <= 1'b0;
    grid_cfg = c;
  endtask

  // ---------------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------------
  function automatic particle_req_t make_add(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                             logic [POS_W-1:0] pz, logic own,
                                             logic [RAD_W-1:0] rad);
    particle_req_t r;
    r.op = OP_ADD;
    r.pos_x = px;
    r.pos_y = py;
    r.pos_z = pz;
    r.own_radius = own;
    r.radius = rad;
    r.read_index = '0;
    return r;
  endfunction

  function automatic particle_req_t make_read(logic [1:0] op, logic [IDX_W-1:0] idx);
    particle_req_t r;
    r = make_add('0, '0, '0, 1'b0, '0);
    r.op = op;
    r.read_index = idx;
    return r;
  endfunction

  // position mostly inside or just around the grid, sometimes anywhere or at the rails
  function automatic logic [POS_W-1:0] random_coord(logic [31:0] origin, logic [31:0] scale);
    longint unsigned span;
    longint unsigned ahead;
    longint unsigned behind;
    longint          base;
    int unsigned     pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) return $urandom;
    if (pick < 18) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return origin;
        default: return origin - 32'd1;
      endcase
    end
    // distance covering the grid plus one voxel
    if (scale == 0) begin
      span = 64'd1 << 20;
    end else begin
      span = longint'(GRID_MAX + 1) << 32;
      span = span / scale;
    end
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    ahead = $urandom_range(0, 32'(span));
    behind = $urandom_range(0, 32'(span >> 4));
    base = $signed(origin);
    return 32'(base + longint'(ahead) - longint'(behind));
  endfunction

  function automatic particle_req_t random_particle();
    particle_req_t r;
    int unsigned   pick;
    pick = $urandom_range(0, 99);
    if (pick < 65)      r.op = OP_ADD;
    else if (pick < 80) r.op = OP_READ;
    else if (pick < 95) r.op = OP_READ_CLR;
    else                r.op = OP_READ_ALT;
    r.pos_x = random_coord(grid_cfg.origin_x, grid_cfg.scale_x);
    r.pos_y = random_coord(grid_cfg.origin_y, grid_cfg.scale_y);
    r.pos_z = random_coord(grid_cfg.origin_z, grid_cfg.scale_z);
    r.own_radius = $urandom_range(0, 1);
    // spread of magnitudes: most radii stay small enough to accumulate
    r.radius = RAD_W'($urandom >> $urandom_range(4, 31));
    // reads mostly revisit voxels that were just filled
    if (hot_cells.size() != 0 && $urandom_range(0, 9) < 7)
      r.read_index = hot_cells[$urandom_range(0, hot_cells.size() - 1)];
    else
      r.read_index = IDX_W'($urandom);
    return r;
  endfunction

  function automatic logic [31:0] random_origin();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
    endcase
  endfunction

  function automatic logic [31:0] random_scale();
    case ($urandom_range(0, 19))
      0, 1:       return 32'd0;
      2, 3, 4:    return RST_SCALE;
      5, 6, 7:    return $urandom;
      default:    return $urandom_range(32'h0000_2000, 32'h0008_0000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // store must read back zero after the clearing pass, code three reads too
  task automatic test_reset_state();
    send_request(make_read(OP_READ, 12'd0));
    send_request(make_read(OP_READ, 12'hFFF));
    send_request(make_read(OP_READ_ALT, 12'hA5A));
  endtask

  // default config: clamping at both rails, zero radius, accumulation into saturation
  task automatic test_default_adds();
    send_request(make_add(32'h0, 32'h0, 32'h0, 1'b0, 24'h0));
    send_request(make_add(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 24'h0));
    // radius 16.0 four times into the far corner, the last add clips
    repeat (4) send_request(make_add(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     1'b1, 24'h10_0000));
    // largest radius clips a fresh voxel at once
    send_request(make_add(32'h0003_8000, 32'h0007_4000, 32'h000F_FD70, 1'b1, 24'hFF_FFFF));
    // exact voxel boundaries with the global radius
    send_request(make_add(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0, 24'h0));
    // read-and-clear returns the held value, the following read sees zero
    send_request(make_read(OP_READ_CLR, 12'hFFF));
    send_request(make_read(OP_READ, 12'hFFF));
    send_request(make_read(OP_READ_CLR, 12'd801));
  endtask

  // every register at its extremes
  task automatic test_config_extremes();
    cfg_regs_t c;
    c.origin_x = 32'h8000_0000;
    c.origin_y = 32'h8000_0000;
    c.origin_z = 32'h8000_0000;
    c.scale_x = 32'hFFFF_FFFF;
    c.scale_y = 32'hFFFF_FFFF;
    c.scale_z = 32'hFFFF_FFFF;
    c.density_scale = 32'hFFFF_FFFF;
    c.global_radius = 24'hFF_FFFF;
    load_grid_config(c);
    send_request(make_add(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 24'h0));
    // tiny radius rounds to nothing; widest span clamps
    send_request(make_add(32'h8000_0001, 32'h7FFF_FFFF, 32'h0, 1'b1, 24'h00_0001));
    send_request(make_add(32'h8000_0001, 32'h8001_0000, 32'h8000_0000, 1'b1, 24'h01_0000));
    send_request(make_read(OP_READ, 12'd4080));

    c.origin_x = 32'h7FFF_FFFF;
    c.origin_y = 32'h7FFF_FFFF;
    c.origin_z = 32'h7FFF_FFFF;
    c.scale_x = 32'h0;
    c.scale_y = 32'h0;
    c.scale_z = 32'h0;
    c.density_scale = 32'h0;
    c.global_radius = 24'h0;
    load_grid_config(c);
    // adding zero to a full voxel must not flag
    send_request(make_add(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 24'h0));
    send_request(make_add(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b1, 24'hFF_FFFF));
    send_request(make_read(OP_READ_CLR, 12'd0));
    send_request(make_read(OP_READ, 12'd0));
  endtask

  // random configs, each followed by a stream of random requests
  task automatic test_random_binning();
    cfg_regs_t c;
    int        idle_levels[6] = '{35, 0, 60, 15, 40, 0};
    for (int phase = 0; phase < 6; phase++) begin
      c.origin_x = random_origin();
      c.origin_y = random_origin();
      c.origin_z = random_origin();
      c.scale_x = random_scale();
      c.scale_y = random_scale();
      c.scale_z = random_scale();
      case ($urandom_range(0, 3))
        0:       c.density_scale = RST_DENSITY_SCALE;
        1:       c.density_scale = $urandom;
        default: c.density_scale = $urandom >> $urandom_range(0, 31);
      endcase
      c.global_radius = RAD_W'($urandom >> $urandom_range(4, 31));
      load_grid_config(c);
      // last phase runs with no idling at all
      idle_pct = idle_levels[phase];
      repeat (155) send_request(random_particle());
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    // known values on every input from time zero
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_operation  <= OP_ADD;
    in_pos_x      <= '0;
    in_pos_y      <= '0;
    in_pos_z      <= '0;
    in_own_radius <= 1'b0;
    in_radius     <= '0;
    in_read_index <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_ORIGIN_X;
    cfg_data      <= '0;
    // model starts from the reset state
    grid_cfg.origin_x = RST_ORIGIN;
    grid_cfg.origin_y = RST_ORIGIN;
    grid_cfg.origin_z = RST_ORIGIN;
    grid_cfg.scale_x = RST_SCALE;
    grid_cfg.scale_y = RST_SCALE;
    grid_cfg.scale_z = RST_SCALE;
    grid_cfg.density_scale = RST_DENSITY_SCALE;
    grid_cfg.global_radius = RST_GLOBAL_RADIUS;
    foreach (voxel_store[i]) voxel_store[i] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests see some idling; busy holds them off during the clear pass
    idle_pct = 30;
    test_reset_state();
    test_default_adds();
    test_config_extremes();
    test_random_binning();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
